[rtl/svpwm_compare_generator_core_macros.svh]
// Assertion macros used by the compare generator top level.
`ifndef SVPWM_COMPARE_GENERATOR_CORE_MACROS_SVH
`define SVPWM_COMPARE_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SVP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define SVP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/svp_pkg.sv]
// Shared constants, types and functions for the SVPWM compare generator.
`default_nettype none

package svp_pkg;

    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
    localparam int QDEPTH = SINE_TABLE_DEPTH / 4;
    localparam int QW     = IDX_W - 2;
    localparam int MAG_W  = 15;

    localparam int ANGLE_W = 16;
    localparam int VOLT_W  = 16;
    localparam int CFG_W   = 16;
    localparam int CMP_W   = 15;
    localparam int CODE_W  = 3;

    localparam int K_W = 17;
    localparam logic [K_W-1:0] SQRT3_Q16 = 17'd113512;

    localparam int PROD_W = 2 * VOLT_W;          // d*cos and friends
    localparam int AK_W   = PROD_W + K_W + 1;    // alpha * sqrt3
    localparam int VW     = 35;                  // a2/b2/c2, signed
    localparam int WW     = VW - 1;              // active times, unsigned
    localparam int SUM_W  = VW;
    localparam int SK_W   = SUM_W + K_W;
    localparam int NW     = 31;                  // normalised sum width
    localparam int SH_W   = 3;
    localparam int TK_W   = 32;
    localparam int DIV_HALF  = 32;
    localparam int DIV_NUM_W = 2 * DIV_HALF;
    localparam int DEN_W     = NW;
    localparam int DIV_STEPS = DIV_HALF;
    localparam int MUL_W     = CFG_W + TK_W;

    // Sector codes, A + 2B + 4C
    localparam logic [CODE_W-1:0] SEC_1 = 3'd3;
    localparam logic [CODE_W-1:0] SEC_2 = 3'd1;
    localparam logic [CODE_W-1:0] SEC_3 = 3'd5;
    localparam logic [CODE_W-1:0] SEC_4 = 3'd4;
    localparam logic [CODE_W-1:0] SEC_5 = 3'd6;
    localparam logic [CODE_W-1:0] SEC_6 = 3'd2;
    localparam logic [CODE_W-1:0] SEC_ZERO    = 3'd0;   // zero vector
    localparam logic [CODE_W-1:0] SEC_INVALID = 3'd7;   // all three signs set

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Taylor series divisors (2n)*(2n+1) for the x^3 .. x^13 terms
    localparam longint unsigned TAYLOR_D3  = 64'd6;
    localparam longint unsigned TAYLOR_D5  = 64'd20;
    localparam longint unsigned TAYLOR_D7  = 64'd42;
    localparam longint unsigned TAYLOR_D9  = 64'd72;
    localparam longint unsigned TAYLOR_D11 = 64'd110;
    localparam longint unsigned TAYLOR_D13 = 64'd156;

    typedef logic [QDEPTH-1:0][MAG_W-1:0] qtab_t;

    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
        logic              ovr;
    } svp_tag_t;

    typedef struct packed {
        logic [DIV_HALF-1:0] rem;
        logic [DIV_HALF-1:0] low;
        logic [DEN_W-1:0]    den;
    } svp_div_lane_t;

    // term * x^2 in Q30
    function automatic longint unsigned taylor_next(input longint unsigned term,
                                                    input longint unsigned x);
        longint unsigned t;
        t = (term * x) >> 30;
        t = (t * x) >> 30;
        return t;
    endfunction

    // Quarter-wave sine magnitude at n/QDEPTH of a quarter turn, Q0.15
    function automatic logic [MAG_W-1:0] quarter_mag(input int unsigned n);
        longint unsigned u;
        longint unsigned x;
        longint unsigned term;
        longint unsigned acc;
        longint unsigned mag;
        u    = longint'(n) << (30 - QW);
        x    = (u * HALF_PI_Q30) >> 30;
        acc  = x;
        term = taylor_next(x, x) / TAYLOR_D3;
        acc  = (acc > term) ? acc - term : 64'd0;
        term = taylor_next(term, x) / TAYLOR_D5;
        acc  = acc + term;
        term = taylor_next(term, x) / TAYLOR_D7;
        acc  = (acc > term) ? acc - term : 64'd0;
        term = taylor_next(term, x) / TAYLOR_D9;
        acc  = acc + term;
        term = taylor_next(term, x) / TAYLOR_D11;
        acc  = (acc > term) ? acc - term : 64'd0;
        term = taylor_next(term, x) / TAYLOR_D13;
        acc  = acc + term;
        mag = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
        if (mag > 64'd32767)
        begin
            mag = 64'd32767;
        end
        return MAG_W'(mag);
    endfunction

    function automatic qtab_t build_qtab();
        qtab_t t;
        for (int k = 0; k < QDEPTH; k++)
        begin
            t[k] = quarter_mag(k);
        end
        return t;
    endfunction

    localparam qtab_t            QTAB = build_qtab();
    localparam logic [MAG_W-1:0] QTOP = quarter_mag(QDEPTH);

    // Full-turn signed sine from the quarter-wave table
    function automatic logic signed [VOLT_W-1:0] sine_lookup(input logic [IDX_W-1:0] k);
        logic [1:0]       quad;
        logic [QW-1:0]    rem;
        logic [QW-1:0]    nrem;
        logic [MAG_W-1:0] mag;
        quad = k[IDX_W-1 -: 2];
        rem  = k[QW-1:0];
        nrem = ~rem + QW'(1);
        if (!quad[0])
        begin
            mag = QTAB[rem];
        end
        else if (rem == '0)
        begin
            mag = QTOP;
        end
        else
        begin
            mag = QTAB[nrem];
        end
        return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    function automatic svp_div_lane_t div_init(input logic [DIV_NUM_W-1:0] num,
                                               input logic [DEN_W-1:0] den);
        svp_div_lane_t l;
        l.rem = num[DIV_NUM_W-1:DIV_HALF];
        l.low = num[DIV_HALF-1:0];
        l.den = den;
        return l;
    endfunction

    // One restoring division step; quotient bits shift in at the bottom of low
    function automatic svp_div_lane_t div_step(input svp_div_lane_t l);
        svp_div_lane_t     r;
        logic [DIV_HALF:0] t;
        logic              ge;
        t     = {l.rem, l.low[DIV_HALF-1]};
        ge    = (t >= (DIV_HALF+1)'(l.den));
        r.den = l.den;
        r.low = {l.low[DIV_HALF-2:0], ge};
        r.rem = ge ? DIV_HALF'(t - (DIV_HALF+1)'(l.den)) : t[DIV_HALF-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/svp_sincos.sv]
// Input stage: table index, sine/cosine lookup and command capture.
`default_nettype none

module svp_sincos
    import svp_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      adv,
    input  wire logic                      in_valid,
    input  wire logic signed [VOLT_W-1:0]  d_voltage,
    input  wire logic signed [VOLT_W-1:0]  q_voltage,
    input  wire logic [ANGLE_W-1:0]        electrical_angle,
    output logic                           s1_valid,
    output logic signed [VOLT_W-1:0]       s1_d,
    output logic signed [VOLT_W-1:0]       s1_q,
    output logic signed [VOLT_W-1:0]       s1_sin,
    output logic signed [VOLT_W-1:0]       s1_cos
);

    logic                     valid_reg;
    logic signed [VOLT_W-1:0] d_reg;
    logic signed [VOLT_W-1:0] q_reg;
    logic signed [VOLT_W-1:0] sin_reg;
    logic signed [VOLT_W-1:0] cos_reg;
    logic [IDX_W-1:0]         idx;
    logic [IDX_W-1:0]         cidx;

    assign idx  = electrical_angle[ANGLE_W-1 -: IDX_W];
    assign cidx = idx + IDX_W'(QDEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg   <= d_voltage;
            q_reg   <= q_voltage;
            sin_reg <= sine_lookup(idx);
            cos_reg <= sine_lookup(cidx);
        end
    end

    assign s1_valid = valid_reg;
    assign s1_d     = d_reg;
    assign s1_q     = q_reg;
    assign s1_sin   = sin_reg;
    assign s1_cos   = cos_reg;

endmodule

`default_nettype wire

[rtl/svp_vector.sv]
// Inverse Park, sqrt3 scaling, sector test and active-vector selection.
`default_nettype none

module svp_vector
    import svp_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      adv,
    input  wire logic                      s1_valid,
    input  wire logic signed [VOLT_W-1:0]  s1_d,
    input  wire logic signed [VOLT_W-1:0]  s1_q,
    input  wire logic signed [VOLT_W-1:0]  s1_sin,
    input  wire logic signed [VOLT_W-1:0]  s1_cos,
    output svp_tag_t                       s6_tag,
    output logic [WW-1:0]                  s6_wa,
    output logic [WW-1:0]                  s6_wb,
    output logic [SUM_W-1:0]               s6_sum
);

    logic                     s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic                     s5_valid_reg, s6_valid_reg;
    logic signed [PROD_W-1:0] pdc_reg, pqs_reg, pds_reg, pqc_reg;
    logic signed [PROD_W-1:0] alpha_reg, beta_reg, beta4_reg;
    logic signed [AK_W-1:0]   ak_reg;
    logic signed [VW-1:0]     a2_reg, b2_reg, c2_reg;
    logic [CODE_W-1:0]        code5_reg, code6_reg;
    logic [WW-1:0]            wa_reg, wb_reg;
    logic [SUM_W-1:0]         sum_reg;

    logic [AK_W-1:0]          ak_adj;
    logic signed [AK_W-17:0]  s_q;
    logic signed [VW-1:0]     sx, bx, a2_next, b2_next, c2_next;
    logic [CODE_W-1:0]        code_next;
    logic signed [VW-1:0]     wsa, wsb;
    logic [WW-1:0]            wa_next, wb_next;

    // truncation toward zero of alpha*sqrt3 / 2^16
    assign ak_adj  = ak_reg + (ak_reg[AK_W-1] ? AK_W'(65535) : AK_W'(0));
    assign s_q     = $signed(ak_adj[AK_W-1:16]);
    assign sx      = VW'(s_q);
    assign bx      = VW'(beta4_reg);
    assign a2_next = bx <<< 1;
    assign b2_next = sx - bx;
    assign c2_next = -sx - bx;
    assign code_next = {(!c2_next[VW-1] && (c2_next != '0)),
                        (!b2_next[VW-1] && (b2_next != '0)),
                        (!a2_next[VW-1] && (a2_next != '0))};

    always_comb
    begin
        wsa = '0;
        wsb = '0;
        case (code5_reg)
            SEC_1:   begin wsa = b2_reg;  wsb = a2_reg;  end
            SEC_2:   begin wsa = -b2_reg; wsb = -c2_reg; end
            SEC_3:   begin wsa = a2_reg;  wsb = c2_reg;  end
            SEC_4:   begin wsa = -a2_reg; wsb = b2_reg;  end
            SEC_5:   begin wsa = c2_reg;  wsb = b2_reg;  end
            SEC_6:   begin wsa = -c2_reg; wsb = -a2_reg; end
            default: begin wsa = '0;      wsb = '0;      end
        endcase
    end

    // negative times saturate to zero
    assign wa_next = wsa[VW-1] ? '0 : wsa[WW-1:0];
    assign wb_next = wsb[VW-1] ? '0 : wsb[WW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pdc_reg   <= s1_d * s1_cos;
            pqs_reg   <= s1_q * s1_sin;
            pds_reg   <= s1_d * s1_sin;
            pqc_reg   <= s1_q * s1_cos;
            alpha_reg <= pdc_reg - pqs_reg;
            beta_reg  <= pds_reg + pqc_reg;
            ak_reg    <= alpha_reg * $signed({1'b0, SQRT3_Q16});
            beta4_reg <= beta_reg;
            a2_reg    <= a2_next;
            b2_reg    <= b2_next;
            c2_reg    <= c2_next;
            code5_reg <= code_next;
            wa_reg    <= wa_next;
            wb_reg    <= wb_next;
            sum_reg   <= {1'b0, wa_next} + {1'b0, wb_next};
            code6_reg <= code5_reg;
        end
    end

    assign s6_tag.valid = s6_valid_reg;
    assign s6_tag.code  = code6_reg;
    assign s6_tag.ovr   = 1'b0;
    assign s6_wa        = wa_reg;
    assign s6_wb        = wb_reg;
    assign s6_sum       = sum_reg;

endmodule

`default_nettype wire

[rtl/svp_times.sv]
// Overrun test, sum normalisation and divider operand set-up.
`default_nettype none

module svp_times
    import svp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   adv,
    input  wire logic [CFG_W-1:0]       bus_eff,
    input  wire logic [CFG_W-1:0]       period,
    input  wire svp_tag_t               s6_tag,
    input  wire logic [WW-1:0]          s6_wa,
    input  wire logic [WW-1:0]          s6_wb,
    input  wire logic [SUM_W-1:0]       s6_sum,
    output svp_tag_t                    s9_tag,
    output logic [DIV_NUM_W-1:0]        num_a,
    output logic [DEN_W-1:0]            den_a,
    output logic [DIV_NUM_W-1:0]        num_b,
    output logic [DEN_W-1:0]            den_b
);

    svp_tag_t             tag7_reg, tag8_reg, tag9_reg;
    logic [SK_W-1:0]      sumk_reg;
    logic [TK_W-1:0]      wak7_reg, wbk7_reg, wak8_reg, wbk8_reg;
    logic [WW-1:0]        wa7_reg;
    logic [SUM_W-1:0]     sum7_reg;
    logic [NW-1:0]        wan_reg, sumn_reg;
    logic [DIV_NUM_W-1:0] numa_reg, numb_reg;
    logic [DEN_W-1:0]     dena_reg;

    logic [WW+K_W-1:0]    wak_full, wbk_full;
    logic                 ovr_next;
    svp_tag_t             tag8_next;
    logic [SH_W-1:0]      sh;
    logic [SUM_W-1:0]     wa_sh, sum_sh;
    logic [MUL_W-1:0]     ma, mb;
    logic [DIV_NUM_W-1:0] numa_next;

    assign wak_full = s6_wa * SQRT3_Q16;
    assign wbk_full = s6_wb * SQRT3_Q16;
    assign ovr_next = sumk_reg > SK_W'({bus_eff, 16'd0});

    assign tag8_next = {tag7_reg.valid, tag7_reg.code, ovr_next};

    // smallest shift that brings the sum below 2^31
    always_comb
    begin
        sh = '0;
        for (int i = 1; i <= SUM_W - NW; i++)
        begin
            if (sum7_reg[NW-1+i])
            begin
                sh = SH_W'(i);
            end
        end
    end

    assign wa_sh  = {1'b0, wa7_reg} >> sh;
    assign sum_sh = sum7_reg >> sh;

    assign ma = period * (tag8_reg.ovr ? {1'b0, wan_reg} : wak8_reg);
    assign mb = period * wbk8_reg;
    assign numa_next = tag8_reg.ovr ? {ma, 16'd0}
                                    : DIV_NUM_W'(ma[MUL_W-1:16]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag7_reg <= '0;
            tag8_reg <= '0;
            tag9_reg <= '0;
        end
        else if (adv)
        begin
            tag7_reg <= s6_tag;
            tag8_reg <= tag8_next;
            tag9_reg <= tag8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sumk_reg <= s6_sum * SQRT3_Q16;
            wak7_reg <= wak_full[TK_W-1:0];
            wbk7_reg <= wbk_full[TK_W-1:0];
            wa7_reg  <= s6_wa;
            sum7_reg <= s6_sum;
            wan_reg  <= wa_sh[NW-1:0];
            sumn_reg <= sum_sh[NW-1:0];
            wak8_reg <= wak7_reg;
            wbk8_reg <= wbk7_reg;
            numa_reg <= numa_next;
            dena_reg <= tag8_reg.ovr ? sumn_reg : DEN_W'(bus_eff);
            numb_reg <= DIV_NUM_W'(mb[MUL_W-1:16]);
        end
    end

    assign s9_tag = tag9_reg;
    assign num_a  = numa_reg;
    assign den_a  = dena_reg;
    assign num_b  = numb_reg;
    assign den_b  = DEN_W'(bus_eff);

endmodule

`default_nettype wire

[rtl/svp_div.sv]
// Two-lane pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module svp_div
    import svp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   adv,
    input  wire svp_tag_t               tag_in,
    input  wire logic [DIV_NUM_W-1:0]   num_a,
    input  wire logic [DEN_W-1:0]       den_a,
    input  wire logic [DIV_NUM_W-1:0]   num_b,
    input  wire logic [DEN_W-1:0]       den_b,
    output svp_tag_t                    tag_out,
    output logic [DIV_HALF-1:0]         quo_a,
    output logic [DIV_HALF-1:0]         quo_b
);

    svp_tag_t      tag_reg  [DIV_STEPS];
    svp_div_lane_t lane_a_reg [DIV_STEPS];
    svp_div_lane_t lane_b_reg [DIV_STEPS];

    for (genvar g = 0; g < DIV_STEPS; g++)
    begin : g_step
        svp_tag_t      tag_src;
        svp_div_lane_t a_src, b_src;

        if (g == 0)
        begin : g_first
            assign tag_src = tag_in;
            assign a_src   = div_init(num_a, den_a);
            assign b_src   = div_init(num_b, den_b);
        end
        else
        begin : g_rest
            assign tag_src = tag_reg[g-1];
            assign a_src   = lane_a_reg[g-1];
            assign b_src   = lane_b_reg[g-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[g] <= '0;
            end
            else if (adv)
            begin
                tag_reg[g] <= tag_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                lane_a_reg[g] <= div_step(a_src);
                lane_b_reg[g] <= div_step(b_src);
            end
        end
    end

    assign tag_out = tag_reg[DIV_STEPS-1];
    assign quo_a   = lane_a_reg[DIV_STEPS-1].low;
    assign quo_b   = lane_b_reg[DIV_STEPS-1].low;

endmodule

`default_nettype wire

[rtl/svpwm_compare_generator_core.sv]
// Top level of the space-vector PWM compare generator with inverse Park front end.
//
// Input channel (in_valid/in_stall): one transaction carries a d/q voltage
// command and an electrical angle. Output channel (out_valid/out_stall): one
// transaction carries three phase compare values and the sector code.
// A new input transaction can be taken every clock while in_stall is low; the
// datapath is a 41-stage pipeline (table lookup, inverse Park, sqrt3 scaling,
// sector and time selection, overrun test and scaling, then a 32-stage
// divider giving one quotient bit per stage). Throughput is one transaction
// per cycle while in_stall is low.
// The output register is backed by a one-entry skid buffer: while the
// receiver stalls, the pipeline keeps moving until the skid buffer fills;
// only then is in_stall raised and the whole pipeline frozen.
// bus_voltage and pwm_period must be written through the APB port only while
// the block is empty, which is not enforced. Reset clears all valid flags and
// loads the register defaults (bus 24576, period 8400); no clearing pass needed.
`default_nettype none

`include "svpwm_compare_generator_core_macros.svh"

module svpwm_compare_generator_core
    import svp_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic signed [VOLT_W-1:0]  d_voltage,
    input  wire logic signed [VOLT_W-1:0]  q_voltage,
    input  wire logic [ANGLE_W-1:0]        electrical_angle,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [CMP_W-1:0]               compare_phase_a,
    output logic [CMP_W-1:0]               compare_phase_b,
    output logic [CMP_W-1:0]               compare_phase_c,
    output logic [CODE_W-1:0]              sector_code,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [2:0]                paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam logic REG_BUS_VOLTAGE = 1'b0;
    localparam logic REG_PWM_PERIOD  = 1'b1;

    typedef struct packed {
        logic [CMP_W-1:0]  cmp_a;
        logic [CMP_W-1:0]  cmp_b;
        logic [CMP_W-1:0]  cmp_c;
        logic [CODE_W-1:0] code;
    } result_t;

    // config registers
    logic [CFG_W-1:0] bus_voltage_reg;
    logic [CFG_W-1:0] pwm_period_reg;
    logic [CFG_W-1:0] bus_eff;

    // pipeline interconnect
    logic                     adv;
    logic                     s1_valid;
    logic signed [VOLT_W-1:0] s1_d, s1_q, s1_sin, s1_cos;
    svp_tag_t                 s6_tag, s9_tag, fin_tag;
    logic [WW-1:0]            s6_wa, s6_wb;
    logic [SUM_W-1:0]         s6_sum;
    logic [DIV_NUM_W-1:0]     num_a, num_b;
    logic [DEN_W-1:0]         den_a, den_b;
    logic [DIV_HALF-1:0]      quo_a, quo_b;

    // final assembly and output buffering
    logic [DIV_HALF-1:0]      p16, ta, tb;
    logic [DIV_HALF+1:0]      v1, v2, v3;
    logic [CMP_W-1:0]         c1, c2, c3;
    result_t                  res;
    result_t                  out_reg, skid_reg;
    logic                     out_valid_reg, skid_valid_reg;
    logic                     out_free;

    //--------------------------------------------------------------------
    // APB register file; pready is tied high, so a write lands in the
    // access phase
    //--------------------------------------------------------------------
    assign pready  = 1'b1;
    assign bus_eff = (bus_voltage_reg == '0) ? CFG_W'(1) : bus_voltage_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_voltage_reg <= 16'd24576;
            pwm_period_reg  <= 16'd8400;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[2])
                REG_BUS_VOLTAGE: bus_voltage_reg <= pwdata[CFG_W-1:0];
                REG_PWM_PERIOD:  pwm_period_reg  <= pwdata[CFG_W-1:0];
                default:         bus_voltage_reg <= bus_voltage_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_BUS_VOLTAGE: prdata = 32'(bus_voltage_reg);
            REG_PWM_PERIOD:  prdata = 32'(pwm_period_reg);
            default:         prdata = '0;
        endcase
    end

    //--------------------------------------------------------------------
    // Pipeline: everything moves together unless the skid buffer is full
    //--------------------------------------------------------------------
    assign adv      = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    svp_sincos u_sincos (
        .clk              (clk),
        .rst_n            (rst_n),
        .adv              (adv),
        .in_valid         (in_valid),
        .d_voltage        (d_voltage),
        .q_voltage        (q_voltage),
        .electrical_angle (electrical_angle),
        .s1_valid         (s1_valid),
        .s1_d             (s1_d),
        .s1_q             (s1_q),
        .s1_sin           (s1_sin),
        .s1_cos           (s1_cos)
    );

    svp_vector u_vector (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .s1_valid (s1_valid),
        .s1_d     (s1_d),
        .s1_q     (s1_q),
        .s1_sin   (s1_sin),
        .s1_cos   (s1_cos),
        .s6_tag   (s6_tag),
        .s6_wa    (s6_wa),
        .s6_wb    (s6_wb),
        .s6_sum   (s6_sum)
    );

    svp_times u_times (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .bus_eff (bus_eff),
        .period  (pwm_period_reg),
        .s6_tag  (s6_tag),
        .s6_wa   (s6_wa),
        .s6_wb   (s6_wb),
        .s6_sum  (s6_sum),
        .s9_tag  (s9_tag),
        .num_a   (num_a),
        .den_a   (den_a),
        .num_b   (num_b),
        .den_b   (den_b)
    );

    svp_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .tag_in  (s9_tag),
        .num_a   (num_a),
        .den_a   (den_a),
        .num_b   (num_b),
        .den_b   (den_b),
        .tag_out (fin_tag),
        .quo_a   (quo_a),
        .quo_b   (quo_b)
    );

    //--------------------------------------------------------------------
    // Seven-segment compares. On overrun tb fills the rest of the period.
    // Only bits 32..18 of each sum are kept, so 34-bit arithmetic suffices.
    //--------------------------------------------------------------------
    assign p16 = {pwm_period_reg, 16'd0};
    assign ta  = quo_a;
    assign tb  = fin_tag.ovr ? (p16 - quo_a) : quo_b;
    assign v1  = {2'b00, p16} - {2'b00, ta} - {2'b00, tb};
    assign v2  = v1 + {1'b0, ta, 1'b0};
    assign v3  = v2 + {1'b0, tb, 1'b0};
    assign c1  = v1[DIV_HALF:18];
    assign c2  = v2[DIV_HALF:18];
    assign c3  = v3[DIV_HALF:18];

    always_comb
    begin
        res.code = fin_tag.code;
        case (fin_tag.code)
            SEC_1:   begin res.cmp_a = c1; res.cmp_b = c2; res.cmp_c = c3; end
            SEC_2:   begin res.cmp_a = c2; res.cmp_b = c1; res.cmp_c = c3; end
            SEC_3:   begin res.cmp_a = c3; res.cmp_b = c1; res.cmp_c = c2; end
            SEC_4:   begin res.cmp_a = c3; res.cmp_b = c2; res.cmp_c = c1; end
            SEC_5:   begin res.cmp_a = c2; res.cmp_b = c3; res.cmp_c = c1; end
            SEC_6:   begin res.cmp_a = c1; res.cmp_b = c3; res.cmp_c = c2; end
            default: begin res.cmp_a = '0; res.cmp_b = '0; res.cmp_c = '0; end // zero vector
        endcase
    end

    //--------------------------------------------------------------------
    // Output register plus skid buffer
    //--------------------------------------------------------------------
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= fin_tag.valid;
            end
        end
        else if (adv && fin_tag.valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        else if (adv && fin_tag.valid)
        begin
            skid_reg <= res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign compare_phase_a = out_reg.cmp_a;
    assign compare_phase_b = out_reg.cmp_b;
    assign compare_phase_c = out_reg.cmp_c;
    assign sector_code     = out_reg.code;

    //--------------------------------------------------------------------
    // Checks
    //--------------------------------------------------------------------
    `SVP_ASSERT_IMPLIES(a_skid_needs_out, clk, rst_n, skid_valid_reg, out_valid_reg, "skid full with output empty")
    `SVP_ASSERT_NEXT(a_skid_fill_on_stall, clk, rst_n, !skid_valid_reg && !(out_valid_reg && out_stall), !skid_valid_reg, "skid filled while output was free")
    `SVP_ASSERT_IMPLIES(a_zero_vector, clk, rst_n, out_valid_reg && (sector_code == SEC_ZERO || sector_code == SEC_INVALID), compare_phase_a == '0 && compare_phase_b == '0 && compare_phase_c == '0, "zero vector with non-zero compares")

endmodule

`default_nettype wire

[dv/tb_svpwm_compare_generator_core.sv]
// Self-checking testbench for the SVPWM compare generator core.
`default_nettype none

module tb_svpwm_compare_generator_core;
    import svp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int REG_BUS    = 0;
    localparam int REG_PERIOD = 1;
    localparam int LATENCY    = 41;
    localparam int WATCHDOG   = 20000;
    localparam int N_RANDOM   = 1250;

    typedef struct packed {
        logic [CMP_W-1:0]  cmp_a;
        logic [CMP_W-1:0]  cmp_b;
        logic [CMP_W-1:0]  cmp_c;
        logic [CODE_W-1:0] code;
    } pwm_result_t;

    typedef struct {
        logic signed [VOLT_W-1:0] d;
        logic signed [VOLT_W-1:0] q;
        logic [ANGLE_W-1:0]       ang;
        bit                       typed;   // expectation given in the row
        pwm_result_t              res;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [VOLT_W-1:0] d_voltage = '0;
    logic signed [VOLT_W-1:0] q_voltage = '0;
    logic [ANGLE_W-1:0] electrical_angle = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [CMP_W-1:0] compare_phase_a;
    logic [CMP_W-1:0] compare_phase_b;
    logic [CMP_W-1:0] compare_phase_c;
    logic [CODE_W-1:0] sector_code;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    svpwm_compare_generator_core u_dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor state: its own copy of the registers and sine table
    int unsigned     bus_set = 24576;
    int unsigned     period_set = 8400;
    longint          sine_q15 [SINE_TABLE_DEPTH];
    pwm_result_t     pending_compares [$];
    int              errors = 0;
    int              results_seen = 0;
    int              idle_cycles = 0;
    int              sectors_hit [8];

    function automatic longint unsigned sine_quarter(longint unsigned u);
        longint unsigned x;
        longint unsigned term;
        longint unsigned acc;
        x    = (u * 64'd1686629713) >> 30;
        term = x;
        acc  = x;
        for (int n = 1; n <= 6; n++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                acc = (acc > term) ? acc - term : 64'd0;
            else
                acc = acc + term;
        end
        return acc;
    endfunction

    task automatic fill_sine();
        longint unsigned four;
        longint unsigned rem;
        longint unsigned u;
        longint unsigned mag;
        int quad;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++)
        begin
            four = longint'(k) * 4;
            quad = int'(four / SINE_TABLE_DEPTH);
            rem  = four % SINE_TABLE_DEPTH;
            u    = (rem << 30) / SINE_TABLE_DEPTH;
            if (quad % 2 == 1)
                u = (64'd1 << 30) - u;
            mag = (sine_quarter(u) * 32767 + (64'd1 << 29)) >> 30;
            if (mag > 32767)
                mag = 32767;
            sine_q15[k] = (quad >= 2) ? -longint'(mag) : longint'(mag);
        end
    endtask

    function automatic pwm_result_t svpwm_compares(logic signed [VOLT_W-1:0] dv,
                                                   logic signed [VOLT_W-1:0] qv,
                                                   logic [ANGLE_W-1:0] ang);
        pwm_result_t r;
        longint d, q, sn, cs, al, be, s, a2, b2, c2, sa, sb;
        longint unsigned wa, wb, sum, p16, ta, tb, v1, v2, v3, bus, per;
        int idx, cidx;
        int code;
        r   = '0;
        sa  = 0;
        sb  = 0;
        bus = (bus_set == 0) ? 1 : bus_set;
        per = period_set;
        d   = dv;
        q   = qv;
        idx  = (int'(ang) * SINE_TABLE_DEPTH) >> 16;
        cidx = (idx + SINE_TABLE_DEPTH / 4) % SINE_TABLE_DEPTH;
        sn = sine_q15[idx];
        cs = sine_q15[cidx];
        al = d * cs - q * sn;
        be = d * sn + q * cs;
        s  = (al * 113512) / 65536;   // truncates toward zero
        a2 = 2 * be;
        b2 = s - be;
        c2 = -s - be;
        code = (a2 > 0 ? 1 : 0) + (b2 > 0 ? 2 : 0) + (c2 > 0 ? 4 : 0);
        case (code)
            SEC_1: begin sa = b2;  sb = a2;  end
            SEC_2: begin sa = -b2; sb = -c2; end
            SEC_3: begin sa = a2;  sb = c2;  end
            SEC_4: begin sa = -a2; sb = b2;  end
            SEC_5: begin sa = c2;  sb = b2;  end
            SEC_6: begin sa = -c2; sb = -a2; end
            default: ;
        endcase
        r.code = CODE_W'(code);
        if (code >= 1 && code <= 6)
        begin
            wa  = (sa > 0) ? sa : 0;
            wb  = (sb > 0) ? sb : 0;
            sum = wa + wb;
            p16 = per << 16;
            if (sum * 113512 > (bus << 16))
            begin
                // overrun: shrink both times to fill the period
                while (sum >= (64'd1 << 31))
                begin
                    sum = sum >> 1;
                    wa  = wa >> 1;
                end
                ta = (p16 * wa) / sum;
                tb = p16 - ta;
            end
            else
            begin
                ta = (wa * 113512 * per) / (bus << 16);
                tb = (wb * 113512 * per) / (bus << 16);
            end
            v1 = p16 - ta - tb;
            v2 = v1 + 2 * ta;
            v3 = v2 + 2 * tb;
            v1 = v1 >> 18;
            v2 = v2 >> 18;
            v3 = v3 >> 18;
            case (code)
                SEC_1:   begin r.cmp_a = CMP_W'(v1); r.cmp_b = CMP_W'(v2); r.cmp_c = CMP_W'(v3); end
                SEC_2:   begin r.cmp_a = CMP_W'(v2); r.cmp_b = CMP_W'(v1); r.cmp_c = CMP_W'(v3); end
                SEC_3:   begin r.cmp_a = CMP_W'(v3); r.cmp_b = CMP_W'(v1); r.cmp_c = CMP_W'(v2); end
                SEC_4:   begin r.cmp_a = CMP_W'(v3); r.cmp_b = CMP_W'(v2); r.cmp_c = CMP_W'(v1); end
                SEC_5:   begin r.cmp_a = CMP_W'(v2); r.cmp_b = CMP_W'(v3); r.cmp_c = CMP_W'(v1); end
                default: begin r.cmp_a = CMP_W'(v1); r.cmp_b = CMP_W'(v3); r.cmp_c = CMP_W'(v2); end
            endcase
        end
        return r;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        else if (roll < 93)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 8);
    endfunction

    task automatic reg_write(int idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * idx);
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_BUS)
            bus_set = val[15:0];
        else if (idx == REG_PERIOD)
            period_set = val[15:0];
    endtask

    // One input transaction; valid stays up across back-to-back items
    task automatic send_cmd(logic signed [VOLT_W-1:0] dv, logic signed [VOLT_W-1:0] qv,
                            logic [ANGLE_W-1:0] ang, bit typed, pwm_result_t res);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid         <= 1'b1;
        d_voltage        <= dv;
        q_voltage        <= qv;
        electrical_angle <= ang;
        pending_compares.push_back(typed ? res : svpwm_compares(dv, qv, ang));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Wait until the pipeline has drained before touching the registers
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_compares.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Receiver stall: random gaps, with quiet stretches
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if ((results_seen / 200) % 3 == 2)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            stall_left <= gap_len();
            out_stall  <= 1'b0;
        end
    end

    // Result checker and watchdog
    always @(posedge clk)
    begin
        pwm_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen = results_seen + 1;
            if (pending_compares.size() == 0)
            begin
                $error("unexpected result transaction");
                errors = errors + 1;
            end
            else
            begin
                want = pending_compares.pop_front();
                sectors_hit[sector_code] = sectors_hit[sector_code] + 1;
                if (compare_phase_a !== want.cmp_a)
                begin
                    $error("compare_phase_a exp %0d got %0d", want.cmp_a, compare_phase_a);
                    errors = errors + 1;
                end
                if (compare_phase_b !== want.cmp_b)
                begin
                    $error("compare_phase_b exp %0d got %0d", want.cmp_b, compare_phase_b);
                    errors = errors + 1;
                end
                if (compare_phase_c !== want.cmp_c)
                begin
                    $error("compare_phase_c exp %0d got %0d", want.cmp_c, compare_phase_c);
                    errors = errors + 1;
                end
                if (sector_code !== want.code)
                begin
                    $error("sector_code exp %0d got %0d", want.code, sector_code);
                    errors = errors + 1;
                end
            end
        end
        if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall) || psel))
            idle_cycles = idle_cycles + 1;
        else
            idle_cycles = 0;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Directed rows; zero commands read off at a glance, others predicted
    stim_row_t dir_rows [] = '{
        '{16'sd0, 16'sd0, 16'h0000, 1'b1, '0},
        '{16'sd0, 16'sd0, 16'hFFFF, 1'b1, '0},
        '{16'sh7FFF, 16'sd0, 16'h0000, 1'b0, '0},
        '{-16'sh8000, 16'sd0, 16'h0000, 1'b0, '0},
        '{16'sd0, 16'sh7FFF, 16'h0000, 1'b0, '0},
        '{16'sd0, -16'sh8000, 16'h0000, 1'b0, '0},
        '{16'sh7FFF, 16'sh7FFF, 16'h2000, 1'b0, '0},
        '{-16'sh8000, -16'sh8000, 16'hC000, 1'b0, '0},
        '{16'sd1000, 16'sd0, 16'h2AAA, 1'b0, '0},
        '{16'sd1000, 16'sd0, 16'h5555, 1'b0, '0},
        '{16'sd1000, 16'sd0, 16'h8000, 1'b0, '0},
        '{16'sd1000, 16'sd0, 16'hAAAA, 1'b0, '0},
        '{16'sd1000, 16'sd0, 16'hD555, 1'b0, '0},
        '{16'sd1000, 16'sd0, 16'hFFFF, 1'b0, '0},
        '{16'sd0, 16'sd500, 16'h1555, 1'b0, '0},
        '{16'sd1, 16'sd0, 16'h4000, 1'b0, '0},
        '{-16'sd1, 16'sd1, 16'h7000, 1'b0, '0},
        '{16'sd20000, -16'sd20000, 16'h3000, 1'b0, '0}
    };

    initial
    begin
        int gen;
        int settings_run;
        logic [15:0] bus_pick [5];
        logic [15:0] per_pick [5];
        logic [ANGLE_W-1:0] ang;
        logic signed [VOLT_W-1:0] dv;
        logic signed [VOLT_W-1:0] qv;
        int roll;
        int amp;
        bus_pick = '{16'd1, 16'd65535, 16'd24576, 16'd0, 16'd300};
        per_pick = '{16'd65535, 16'd2, 16'd8400, 16'd1, 16'd0};
        settings_run = 0;
        fill_sine();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values first, then the directed table
        foreach (dir_rows[i])
            send_cmd(dir_rows[i].d, dir_rows[i].q, dir_rows[i].ang,
                     dir_rows[i].typed, dir_rows[i].res);
        drain();
        send_cmd(16'sd3000, 16'sd2000, 16'h1234, 1'b0, '0);
        drain();

        // Random part in phases, each under another register setting
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph < 5)
            begin
                reg_write(REG_BUS, {16'h0, bus_pick[ph]});
                reg_write(REG_PERIOD, {16'h0, per_pick[ph]});
            end
            else
            begin
                reg_write(REG_BUS, $urandom);
                reg_write(REG_PERIOD, $urandom);
            end
            settings_run = settings_run + 1;
            for (gen = 0; gen < N_RANDOM / 6; gen++)
            begin
                roll = $urandom_range(99);
                ang  = ANGLE_W'($urandom);
                if (roll < 10)
                begin
                    dv = VOLT_W'($urandom);   // full range, overruns
                    qv = VOLT_W'($urandom);
                end
                else if (roll < 14)
                begin
                    dv = '0;                  // zero vector
                    qv = '0;
                end
                else
                begin
                    // scaled to the bus so both linear and overrun paths appear
                    amp = (bus_set == 0 ? 1 : bus_set) / 2 + 1;
                    if (amp > 32767)
                        amp = 32767;
                    dv = VOLT_W'(int'($urandom_range(2 * amp)) - amp);
                    qv = VOLT_W'(int'($urandom_range(2 * amp)) - amp);
                end
                send_cmd(dv, qv, ang, 1'b0, '0);
            end
            drain();
        end

        $display("covered %0d results over %0d register settings", results_seen,
                 settings_run);
        $display("sectors seen 0..7: %0d %0d %0d %0d %0d %0d %0d %0d", sectors_hit[0],
                 sectors_hit[1], sectors_hit[2], sectors_hit[3], sectors_hit[4],
                 sectors_hit[5], sectors_hit[6], sectors_hit[7]);
        if (errors == 0 && pending_compares.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/svp_pkg.sv
rtl/svp_sincos.sv
rtl/svp_vector.sv
rtl/svp_times.sv
rtl/svp_div.sv
rtl/svpwm_compare_generator_core.sv
dv/tb_svpwm_compare_generator_core.sv
